// File: design/mdu_pkg.sv
// ----------------------------------------------------------------------------
// mdu_pkg
// shared widths, codes and helpers for the multiply / divide unit
// ----------------------------------------------------------------------------
package mdu_pkg;

    localparam int DATA_W     = 64;
    localparam int DIV_STAGES = DATA_W;
    localparam int MUL_STAGES = 4;

    localparam logic [1:0] KIND_MULU = 2'd0;
    localparam logic [1:0] KIND_MULS = 2'd1;
    localparam logic [1:0] KIND_DIVU = 2'd2;
    localparam logic [1:0] KIND_DIVS = 2'd3;

    localparam logic [1:0] SIZE_8  = 2'd0;
    localparam logic [1:0] SIZE_16 = 2'd1;
    localparam logic [1:0] SIZE_32 = 2'd2;
    localparam logic [1:0] SIZE_64 = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_BAD_SIZE = 2'd1;
    localparam logic [1:0] ST_DIV_ZERO = 2'd2;

    localparam logic [2:0] ADDR_NARROW = 3'd0;

    function automatic logic [DATA_W-1:0] size_mask(input logic [1:0] sz);
        logic [DATA_W-1:0] m;
        case (sz)
            SIZE_8:  m = 64'h0000_0000_0000_00FF;
            SIZE_16: m = 64'h0000_0000_0000_FFFF;
            SIZE_32: m = 64'h0000_0000_FFFF_FFFF;
            default: m = 64'hFFFF_FFFF_FFFF_FFFF;
        endcase
        return m;
    endfunction

    function automatic logic sign_bit(input logic [DATA_W-1:0] v, input logic [1:0] sz);
        logic s;
        case (sz)
            SIZE_8:  s = v[7];
            SIZE_16: s = v[15];
            SIZE_32: s = v[31];
            default: s = v[63];
        endcase
        return s;
    endfunction

endpackage

// File: design/multiply_divide_unit.sv
// ----------------------------------------------------------------------------
// multiply_divide_unit
// integer multiply / divide at 8, 16, 32 or 64 bits, fully pipelined
// ----------------------------------------------------------------------------
// One operation is accepted every cycle while the output is not stalled; the
// prepare stage (masking, sign strip, status) captures the beat at the edge
// that accepts it, then 64 divider stages (one quotient bit each, which sets
// the latency) and the output register follow.
// The multiplier takes four stages and is delayed to line up with the divider.
// The whole pipe moves together; it holds only while the output beat waits.
// Input beat: s_tuser = kind, operand_size; s_tdata = first, second operand.
// Output beat: m_tuser = status; m_tdata = upper_or_quotient, lower_or_remainder.
// ----------------------------------------------------------------------------
module multiply_divide_unit (
    input  logic          clk,
    input  logic          rst_n,
    // input stream
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [127:0]  s_tdata,   // [63:0] first_operand, [127:64] second_operand
    input  logic [3:0]    s_tuser,   // [1:0] kind, [3:2] operand_size
    // output stream
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [127:0]  m_tdata,   // [63:0] upper_or_quotient, [127:64] lower_or_remainder
    output logic [1:0]    m_tuser,   // [1:0] status
    // register port
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [2:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready
);
    import mdu_pkg::*;

    // -------- config register --------
    logic narrow_reg;

    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_NARROW) ? {31'd0, narrow_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            narrow_reg <= 1'b0;
        else if (psel && penable && pwrite && pready && paddr == ADDR_NARROW)
            narrow_reg <= pwdata[0];
    end

    // -------- pipeline advance --------
    logic en;
    logic out_valid_reg;

    // everything shifts unless the output beat is stuck
    assign en       = !out_valid_reg || m_tready;
    assign s_tready = en;

    // -------- prepare stage --------
    logic [1:0]        kind_in, sz_in;
    logic [DATA_W-1:0] mask_in, a_in, b_in;
    logic              an_in, bn_in;

    always_comb
    begin
        kind_in = s_tuser[1:0];
        sz_in   = s_tuser[3:2];
        mask_in = size_mask(sz_in);
        a_in    = s_tdata[63:0] & mask_in;
        b_in    = s_tdata[127:64] & mask_in;
        an_in   = kind_in[0] && sign_bit(a_in, sz_in);
        bn_in   = kind_in[0] && sign_bit(b_in, sz_in);
    end

    logic              pv_reg;
    logic [DATA_W-1:0] pa_reg, pb_reg, pua_reg, pub_reg;
    logic              pan_reg, pbn_reg;
    logic [1:0]        pkind_reg, psz_reg, pst_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pv_reg <= 1'b0;
        else if (en)
            pv_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pa_reg    <= a_in;
            pb_reg    <= b_in;
            pua_reg   <= an_in ? ((~a_in + 64'd1) & mask_in) : a_in;
            pub_reg   <= bn_in ? ((~b_in + 64'd1) & mask_in) : b_in;
            pan_reg   <= an_in;
            pbn_reg   <= bn_in;
            pkind_reg <= kind_in;
            psz_reg   <= sz_in;
            // size fault wins over divide by zero
            if (sz_in == SIZE_64 && narrow_reg)
                pst_reg <= ST_BAD_SIZE;
            else if (kind_in[1] && b_in == '0)
                pst_reg <= ST_DIV_ZERO;
            else
                pst_reg <= ST_OK;
        end
    end

    // -------- arithmetic units --------
    logic [DATA_W-1:0] mul_hi, mul_lo, div_q, div_r;

    mdu_mul u_mul (
        .clk   (clk),
        .en    (en),
        .a     (pa_reg),
        .b     (pb_reg),
        .a_neg (pan_reg),
        .b_neg (pbn_reg),
        .sz    (psz_reg),
        .hi    (mul_hi),
        .lo    (mul_lo)
    );

    mdu_div u_div (
        .clk       (clk),
        .en        (en),
        .dividend  (pua_reg),
        .divisor   (pub_reg),
        .quotient  (div_q),
        .remainder (div_r)
    );

    // -------- sideband line, matches the unit latency --------
    typedef struct packed {
        logic [1:0] kind;
        logic [1:0] sz;
        logic [1:0] st;
        logic       a_neg;
        logic       b_neg;
    } side_t;

    side_t side_reg [DIV_STAGES];
    logic  sv_reg   [DIV_STAGES];

    genvar i;
    generate
        for (i = 0; i < DIV_STAGES; i++)
        begin : g_side
            side_t side_in;
            logic  sv_in;

            if (i == 0)
            begin : g_first
                assign side_in = '{kind: pkind_reg, sz: psz_reg, st: pst_reg,
                                   a_neg: pan_reg, b_neg: pbn_reg};
                assign sv_in   = pv_reg;
            end
            else
            begin : g_rest
                assign side_in = side_reg[i-1];
                assign sv_in   = sv_reg[i-1];
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    sv_reg[i] <= 1'b0;
                else if (en)
                    sv_reg[i] <= sv_in;
            end

            always_ff @(posedge clk)
            begin
                if (en)
                    side_reg[i] <= side_in;
            end
        end
    endgenerate

    // -------- result select and output register --------
    side_t             sd;
    logic [DATA_W-1:0] omask, q_fix, r_fix, r0_next, r1_next;

    always_comb
    begin
        sd    = side_reg[DIV_STAGES-1];
        omask = size_mask(sd.sz);
        // truncation toward zero: quotient sign from both, remainder from dividend
        q_fix = (sd.a_neg != sd.b_neg) ? (~div_q + 64'd1) : div_q;
        r_fix = sd.a_neg ? (~div_r + 64'd1) : div_r;
        if (sd.st != ST_OK)
        begin
            r0_next = '0;
            r1_next = '0;
        end
        else if (sd.kind[1])
        begin
            r0_next = q_fix & omask;
            r1_next = r_fix & omask;
        end
        else
        begin
            r0_next = mul_hi;
            r1_next = mul_lo;
        end
    end

    logic [DATA_W-1:0] r0_reg, r1_reg;
    logic [1:0]        st_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= sv_reg[DIV_STAGES-1];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r0_reg <= r0_next;
            r1_reg <= r1_next;
            st_reg <= sd.st;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {r1_reg, r0_reg};
    assign m_tuser  = st_reg;

endmodule

// File: design/mdu_mul.sv
// ----------------------------------------------------------------------------
// mdu_mul
// pipelined 64x64 multiplier with sign fix-up, padded to the divider latency
// ----------------------------------------------------------------------------
module mdu_mul (
    input  logic                      clk,
    input  logic                      en,
    input  logic [mdu_pkg::DATA_W-1:0] a,
    input  logic [mdu_pkg::DATA_W-1:0] b,
    input  logic                      a_neg,
    input  logic                      b_neg,
    input  logic [1:0]                sz,
    output logic [mdu_pkg::DATA_W-1:0] hi,
    output logic [mdu_pkg::DATA_W-1:0] lo
);
    import mdu_pkg::*;

    localparam int HW  = DATA_W / 2;
    localparam int PW  = 2 * DATA_W;
    localparam int PAD = DIV_STAGES - MUL_STAGES;

    // stage 1: partial products
    logic [DATA_W-1:0] p00_reg, p01_reg, p10_reg, p11_reg;
    logic [DATA_W:0]   corr_reg;
    logic [1:0]        sz1_reg;
    // stage 2: full product and shifted correction
    logic [PW-1:0]     prod_reg, cs_reg;
    logic [1:0]        sz2_reg;
    // stage 3: signed product
    logic [PW-1:0]     sp_reg;
    logic [1:0]        sz3_reg;
    // stage 4: halves
    logic [DATA_W-1:0] hi4_reg, lo4_reg;

    logic [PW-1:0]     cs_next, hi_sh;
    logic [DATA_W-1:0] msk;

    always_comb
    begin
        case (sz1_reg)
            SIZE_8:  cs_next = {{(PW-DATA_W-1){1'b0}}, corr_reg} << 8;
            SIZE_16: cs_next = {{(PW-DATA_W-1){1'b0}}, corr_reg} << 16;
            SIZE_32: cs_next = {{(PW-DATA_W-1){1'b0}}, corr_reg} << 32;
            default: cs_next = {{(PW-DATA_W-1){1'b0}}, corr_reg} << 64;
        endcase
        case (sz3_reg)
            SIZE_8:  hi_sh = sp_reg >> 8;
            SIZE_16: hi_sh = sp_reg >> 16;
            SIZE_32: hi_sh = sp_reg >> 32;
            default: hi_sh = sp_reg >> 64;
        endcase
        msk = size_mask(sz3_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p00_reg  <= DATA_W'(a[HW-1:0])      * DATA_W'(b[HW-1:0]);
            p01_reg  <= DATA_W'(a[HW-1:0])      * DATA_W'(b[DATA_W-1:HW]);
            p10_reg  <= DATA_W'(a[DATA_W-1:HW]) * DATA_W'(b[HW-1:0]);
            p11_reg  <= DATA_W'(a[DATA_W-1:HW]) * DATA_W'(b[DATA_W-1:HW]);
            corr_reg <= (a_neg ? {1'b0, b} : '0) + (b_neg ? {1'b0, a} : '0);
            sz1_reg  <= sz;

            prod_reg <= {{DATA_W{1'b0}}, p00_reg}
                      + ({{DATA_W{1'b0}}, p01_reg} << HW)
                      + ({{DATA_W{1'b0}}, p10_reg} << HW)
                      + {p11_reg, {DATA_W{1'b0}}};
            cs_reg   <= cs_next;
            sz2_reg  <= sz1_reg;

            sp_reg   <= prod_reg - cs_reg;
            sz3_reg  <= sz2_reg;

            hi4_reg  <= hi_sh[DATA_W-1:0] & msk;
            lo4_reg  <= sp_reg[DATA_W-1:0] & msk;
        end
    end

    // delay line so both units land on the same cycle
    logic [PW-1:0] dly_reg [PAD];

    genvar i;
    generate
        for (i = 0; i < PAD; i++)
        begin : g_dly
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    if (i == 0)
                        dly_reg[i] <= {hi4_reg, lo4_reg};
                    else
                        dly_reg[i] <= dly_reg[(i == 0) ? 0 : i-1];
                end
            end
        end
    endgenerate

    assign hi = dly_reg[PAD-1][PW-1:DATA_W];
    assign lo = dly_reg[PAD-1][DATA_W-1:0];

endmodule

// File: design/mdu_div.sv
// ----------------------------------------------------------------------------
// mdu_div
// unsigned restoring divider, one quotient bit per pipeline stage
// ----------------------------------------------------------------------------
module mdu_div (
    input  logic                      clk,
    input  logic                      en,
    input  logic [mdu_pkg::DATA_W-1:0] dividend,
    input  logic [mdu_pkg::DATA_W-1:0] divisor,
    output logic [mdu_pkg::DATA_W-1:0] quotient,
    output logic [mdu_pkg::DATA_W-1:0] remainder
);
    import mdu_pkg::*;

    // per stage: partial remainder, dividend bits shifting out / quotient in
    logic [DATA_W-1:0] rem_reg [DIV_STAGES];
    logic [DATA_W-1:0] dq_reg  [DIV_STAGES];
    logic [DATA_W-1:0] dv_reg  [DIV_STAGES];

    genvar i;
    generate
        for (i = 0; i < DIV_STAGES; i++)
        begin : g_stage
            logic [DATA_W-1:0] rem_in, dq_in, dv_in;
            logic [DATA_W:0]   shifted;
            logic [DATA_W+1:0] diff;
            logic              ge;

            if (i == 0)
            begin : g_first
                assign rem_in = '0;
                assign dq_in  = dividend;
                assign dv_in  = divisor;
            end
            else
            begin : g_rest
                assign rem_in = rem_reg[i-1];
                assign dq_in  = dq_reg[i-1];
                assign dv_in  = dv_reg[i-1];
            end

            assign shifted = {rem_in, dq_in[DATA_W-1]};
            assign diff    = {1'b0, shifted} - {2'b00, dv_in};
            assign ge      = ~diff[DATA_W+1];

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[i] <= ge ? diff[DATA_W-1:0] : shifted[DATA_W-1:0];
                    dq_reg[i]  <= {dq_in[DATA_W-2:0], ge};
                    dv_reg[i]  <= dv_in;
                end
            end
        end
    endgenerate

    assign quotient  = dq_reg[DIV_STAGES-1];
    assign remainder = rem_reg[DIV_STAGES-1];

endmodule
